// ===== design/jssf_pkg.sv =====
package jssf_pkg;

    // Default width of the stream byte counter.
    localparam int POSITION_BITS_DEFAULT = 32;

    // Fixed payload widths.
    localparam int DATA_BITS   = 8;
    localparam int STATUS_BITS = 2;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;

    // Marker bytes.
    localparam logic [DATA_BITS-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [DATA_BITS-1:0] MARK_SOI    = 8'hD8;
    localparam logic [DATA_BITS-1:0] MARK_SOS    = 8'hDA;
    localparam logic [DATA_BITS-1:0] MARK_RST_LO = 8'hD0;
    localparam logic [DATA_BITS-1:0] MARK_RST_HI = 8'hD7;

    // Smallest legal segment length (the length field counts itself).
    localparam logic [LENGTH_BITS-1:0] MIN_LENGTH = 16'd2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_FOUND = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ENDED = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_SHORT = 2'd2;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_CODE   = 5'b00010,
        PH_LEN_HI = 5'b00100,
        PH_LEN_LO = 5'b01000,
        PH_SKIP   = 5'b10000
    } phase_t;

    // Byte held in the input register.
    typedef struct packed {
        logic                 valid;
        logic [DATA_BITS-1:0] data_byte;
        logic                 last_byte;
    } item_t;

    // Result computed by the parser for the byte in the input register.
    typedef struct packed {
        logic                   valid;
        logic [STATUS_BITS-1:0] status;
        logic [OFFSET_BITS-1:0] scan_offset;
    } result_t;

endpackage

// ===== design/jssf_byte_if.sv =====
interface jssf_byte_if;

    logic                           valid;
    logic                           ready;
    logic [jssf_pkg::DATA_BITS-1:0] data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);

endinterface

// ===== design/jssf_result_if.sv =====
interface jssf_result_if;

    logic                             valid;
    logic                             ready;
    logic [jssf_pkg::STATUS_BITS-1:0] status;
    logic [jssf_pkg::OFFSET_BITS-1:0] scan_offset;

    modport source (output valid, output status, output scan_offset, input ready);
    modport sink (input valid, input status, input scan_offset, output ready);

endinterface

// ===== design/jssf_in_stage.sv =====
module jssf_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    jssf_byte_if.sink       stream,
    input  logic            take,
    output jssf_pkg::item_t item
);
    import jssf_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [DATA_BITS-1:0] data_reg;
    logic                 last_reg;
    logic                 load;

    // A new transaction is taken when the register is empty or drains this cycle.
    assign stream.ready = !valid_reg || take;
    assign load         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (stream.ready)
        begin
            valid_next = stream.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= stream.data_byte;
            last_reg <= stream.last_byte;
        end
    end

    assign item.valid     = valid_reg;
    assign item.data_byte = data_reg;
    assign item.last_byte = last_reg;

endmodule

// ===== design/jssf_parser.sv =====
module jssf_parser #(
    parameter int POSITION_BITS = jssf_pkg::POSITION_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  jssf_pkg::item_t   item,
    input  logic              take,
    output jssf_pkg::result_t res
);
    import jssf_pkg::*;

    phase_t                   phase_reg,   phase_next;
    logic [DATA_BITS-1:0]     prefix_reg,  prefix_next;
    logic [DATA_BITS-1:0]     len_hi_reg,  len_hi_next;
    logic [LENGTH_BITS-1:0]   skip_reg,    skip_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic                     finished_reg, finished_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0]   found_offset;
    logic [LENGTH_BITS-1:0]   seg_length;
    logic [LENGTH_BITS-1:0]   seg_remaining;
    logic [LENGTH_BITS-1:0]   skip_dec;
    logic                     is_restart;
    logic                     have;
    logic [STATUS_BITS-1:0]   status;
    logic [OFFSET_BITS-1:0]   offset;
    logic [DATA_BITS-1:0]     b;
    logic                     last;

    assign b    = item.data_byte;
    assign last = item.last_byte;

    // Position of the byte after this one; the offset is its low bits.
    assign pos_inc      = pos_reg + POSITION_BITS'(1);
    assign found_offset = OFFSET_BITS'(pos_inc);

    assign seg_length    = {len_hi_reg, b};
    assign seg_remaining = seg_length - MIN_LENGTH;
    assign skip_dec      = (skip_reg != '0) ? (skip_reg - LENGTH_BITS'(1)) : skip_reg;
    assign is_restart    = (b >= MARK_RST_LO) && (b <= MARK_RST_HI);

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next    = phase_reg;
        prefix_next   = prefix_reg;
        len_hi_next   = len_hi_reg;
        skip_next     = skip_reg;
        pos_next      = pos_reg;
        finished_next = finished_reg;
        have          = 1'b0;
        status        = STATUS_ENDED;
        offset        = '0;

        if (finished_reg)
        begin
            // Discard the rest of the stream; its last byte re-arms the block.
            if (last)
            begin
                phase_next    = PH_PREFIX;
                prefix_next   = '0;
                len_hi_next   = '0;
                skip_next     = '0;
                pos_next      = '0;
                finished_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    if (prefix_reg == MARK_PREFIX && b == MARK_SOS)
                    begin
                        have   = 1'b1;
                        status = STATUS_FOUND;
                        offset = found_offset;
                    end
                    else if (prefix_reg == MARK_PREFIX && (b == MARK_SOI || is_restart))
                    begin
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (seg_length < MIN_LENGTH)
                    begin
                        have   = 1'b1;
                        status = STATUS_SHORT;
                    end
                    else
                    begin
                        skip_next  = seg_remaining;
                        phase_next = (seg_remaining == '0) ? PH_PREFIX : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_PREFIX;
                    end
                end
                default:
                begin
                    prefix_next = b;
                    phase_next  = PH_CODE;
                end
            endcase

            pos_next = pos_inc;

            // End of stream without any other result.
            if (!have && last)
            begin
                have   = 1'b1;
                status = STATUS_ENDED;
                offset = '0;
            end

            if (have)
            begin
                if (last)
                begin
                    phase_next    = PH_PREFIX;
                    prefix_next   = '0;
                    len_hi_next   = '0;
                    skip_next     = '0;
                    pos_next      = '0;
                    finished_next = 1'b0;
                end
                else
                begin
                    finished_next = 1'b1;
                end
            end
        end
    end

    // State advances only when the byte moves on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREFIX;
            prefix_reg   <= '0;
            len_hi_reg   <= '0;
            skip_reg     <= '0;
            pos_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            prefix_reg   <= prefix_next;
            len_hi_reg   <= len_hi_next;
            skip_reg     <= skip_next;
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

    assign res.valid       = item.valid && have;
    assign res.status      = status;
    assign res.scan_offset = offset;

endmodule

// ===== design/jssf_out_stage.sv =====
module jssf_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  jssf_pkg::result_t res,
    output logic              can_load,
    jssf_result_if.source     result
);
    import jssf_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [STATUS_BITS-1:0] status_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    // The register can be loaded when empty or when its transaction completes now.
    assign can_load = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = take && res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            status_reg <= res.status;
            offset_reg <= res.scan_offset;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = status_reg;
    assign result.scan_offset = offset_reg;

endmodule

// ===== design/jpeg_start_of_scan_finder_unit.sv =====
// Channel   Direction  Payload                          Transaction
// stream    sink       data_byte[7:0], last_byte        one stream byte
// result    source     status[1:0], scan_offset[31:0]   one search result
//
// Each byte passes an input register and a result register. An accepted byte
// waits in the input register until the result register can take its result,
// if any; that result then waits in the result register until it completes. One byte is
// taken every cycle while the result side keeps up. A byte leaves the input
// register only when the result register is free or drains in the same cycle,
// so a stalled result holds the byte behind it and then the stream. Reset
// clears all parser state and both valid flags at once.
module jpeg_start_of_scan_finder_unit #(
    parameter int POSITION_BITS = jssf_pkg::POSITION_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    jssf_byte_if.sink     stream,
    jssf_result_if.source result
);
    import jssf_pkg::*;

    item_t   item;
    result_t res;
    logic    can_load;
    logic    take;

    // The held byte is processed when the result register can accept its outcome.
    assign take = item.valid && can_load;

    jssf_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .take   (take),
        .item   (item)
    );

    jssf_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .res   (res)
    );

    jssf_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .res      (res),
        .can_load (can_load),
        .result   (result)
    );

endmodule
